>>> hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hdl/dss_pkg.sv
// shared types and constants of the delimiter string splitter
package dss_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int WORDS_W  = 16;
    localparam int LEN_W    = 4;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 4;
    localparam int REG_SEL_BIT = 3;

    localparam logic [LEN_W-1:0]  DELIM_LEN_RESET   = 4'd1;
    localparam logic [APB_DW-1:0] DELIM_BYTES_RESET = 64'd42;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic {
        REG_DELIM_LEN   = 1'b0,
        REG_DELIM_BYTES = 1'b1
    } reg_idx_t;

endpackage

>>> hdl/dss_in_if.sv
// input stream interface: one string byte or end-of-string per transfer
interface dss_in_if;
    logic                        valid;
    logic                        ready;
    logic [dss_pkg::BYTE_W-1:0]  data_byte;
    logic                        is_end;

    modport source (output valid, output data_byte, output is_end, input ready);
    modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

>>> hdl/dss_out_if.sv
// output stream interface: one result item per transfer
interface dss_out_if;
    logic                        valid;
    logic                        ready;
    dss_pkg::kind_t              item_kind;
    logic [dss_pkg::BYTE_W-1:0]  word_byte;
    logic [dss_pkg::WORDS_W-1:0] words_found;
    logic                        last_of_run;

    modport source (output valid, output item_kind, output word_byte, output words_found,
                    output last_of_run, input ready);
    modport sink   (input valid, input item_kind, input word_byte, input words_found,
                    input last_of_run, output ready);
endinterface

>>> hdl/delimiter_string_splitter.sv
// delimiter string splitter: splits a byte stream into words at a whole delimiter string
//
// Each input transfer carries one string byte or an end-of-string mark. Bytes that could
// still start the delimiter wait in a window of up to MAX_DELIM-1 bytes; bytes that can no
// longer start it leave as word data, a full delimiter match closes the open word, and an
// end mark flushes the window, closes the open word and reports the saturating word count
// (low 16 bits). Matches are leftmost first, non-overlapping, and empty words are dropped.
// The window compare is fully parallel, so an input item is judged in the cycle it is
// accepted and, when nothing is ahead of it, its results start on the output in the cycle
// after. Results leave one per cycle while the sink takes them: an item yields r results
// (at most MAX_DELIM for a byte, MAX_DELIM+1 for an end mark), and an item with no result
// costs nothing there. Behind the batch being sent sits one holding slot: with a sink that
// takes a result every cycle, input flows at one transfer per cycle while each item yields
// at most one result. While the batch being sent is unfinished, items keep transferring
// until one with results takes the holding slot; the input then waits until the batch being
// sent hands over its last result. Configuration (delimiter_length at 0x0, delimiter_bytes
// at 0x8, first byte in the low bits) must be written over the apb port only while idle,
// which the block itself does not enforce; a length of 0 disables splitting and lengths
// above MAX_DELIM act as MAX_DELIM. No memory, no clearing pass after reset.
`include "assert_macros.svh"

module delimiter_string_splitter #(
    parameter int MAX_DELIM   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dss_pkg::APB_AW-1:0]  paddr,
    input  logic [dss_pkg::APB_DW-1:0]  pwdata,
    output logic [dss_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // streams
    dss_in_if.sink                      in_stream,
    dss_out_if.source                   out_stream
);

    // widths derived from the window depth
    localparam int NB_W  = $clog2(MAX_DELIM + 1);           // 0..MAX_DELIM
    localparam int CNT_W = $clog2(MAX_DELIM + 2);           // 0..MAX_DELIM+1 results
    localparam int IDX_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
    localparam int BW    = dss_pkg::BYTE_W;

    // one item's results: data bytes first, then word end, then string done
    typedef struct packed {
        logic [MAX_DELIM-1:0][BW-1:0] bytes;
        logic [NB_W-1:0]              nbytes;
        logic                         has_end;
        logic                         has_done;
        logic [COUNT_WIDTH-1:0]       count;
    } batch_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [dss_pkg::LEN_W-1:0]  delim_len_reg;
    logic [dss_pkg::APB_DW-1:0] delim_bytes_reg;
    dss_pkg::reg_idx_t          reg_sel;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = dss_pkg::reg_idx_t'(paddr[dss_pkg::REG_SEL_BIT]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_len_reg   <= dss_pkg::DELIM_LEN_RESET;
            delim_bytes_reg <= dss_pkg::DELIM_BYTES_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                dss_pkg::REG_DELIM_LEN:   delim_len_reg   <= pwdata[dss_pkg::LEN_W-1:0];
                dss_pkg::REG_DELIM_BYTES: delim_bytes_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            dss_pkg::REG_DELIM_LEN:
                prdata = {{(dss_pkg::APB_DW - dss_pkg::LEN_W){1'b0}}, delim_len_reg};
            dss_pkg::REG_DELIM_BYTES:
                prdata = delim_bytes_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // string state
    // ------------------------------------------------------------------
    logic [MAX_DELIM-1:0][BW-1:0] window_reg, window_next;
    logic [NB_W-1:0]              fill_reg, fill_next;
    logic                         word_open_reg, word_open_next;
    logic [COUNT_WIDTH-1:0]       word_tally_reg, word_tally_next;

    // output side: batch being sent and one batch held behind it
    batch_t                       cur_reg, pend_reg, new_batch;
    logic                         cur_valid_reg, pend_valid_reg;
    logic [CNT_W-1:0]             idx_reg;

    // ------------------------------------------------------------------
    // window judgement for the incoming byte
    // ------------------------------------------------------------------
    logic [MAX_DELIM-1:0][BW-1:0] delim, ext, shifted;
    logic [NB_W-1:0]              eff_len, n_bytes, m_drop;
    logic [MAX_DELIM-1:0]         sfx_ok;
    logic                         full_match;
    logic [COUNT_WIDTH-1:0]       tally_inc;

    always_comb
    begin
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            delim[i] = delim_bytes_reg[BW*i +: BW];
        end
        // lengths past the window depth clamp to it
        if (delim_len_reg > dss_pkg::LEN_W'(MAX_DELIM))
            eff_len = NB_W'(MAX_DELIM);
        else
            eff_len = NB_W'(delim_len_reg);
    end

    // pending bytes with the new byte appended
    always_comb
    begin
        n_bytes = fill_reg + NB_W'(1);
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            if (NB_W'(i) < fill_reg)
                ext[i] = window_reg[i];
            else if (NB_W'(i) == fill_reg)
                ext[i] = in_stream.data_byte;
            else
                ext[i] = '0;
        end
    end

    // suffix starting at s can stay pending when it is a proper prefix of the delimiter
    always_comb
    begin
        logic ok;
        for (int s = 0; s < MAX_DELIM; s++)
        begin
            ok = (NB_W'(s) < n_bytes) && ((n_bytes - NB_W'(s)) < eff_len);
            for (int i = 0; i < MAX_DELIM; i++)
            begin
                if ((s + i < MAX_DELIM) && (NB_W'(i) < n_bytes - NB_W'(s)))
                    ok = ok && (ext[s+i] == delim[i]);
            end
            sfx_ok[s] = ok;
        end
    end

    // bytes in front of the longest such suffix leave as word data
    always_comb
    begin
        m_drop = n_bytes;
        for (int s = MAX_DELIM - 1; s >= 0; s--)
        begin
            if (sfx_ok[s])
                m_drop = NB_W'(s);
        end
    end

    always_comb
    begin
        full_match = (eff_len != '0) && (n_bytes == eff_len);
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            if ((NB_W'(i) < n_bytes) && (ext[i] != delim[i]))
                full_match = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            shifted[i] = '0;
            for (int j = 0; j < MAX_DELIM; j++)
            begin
                if ((NB_W'(j) < n_bytes) && (int'(m_drop) + i == j))
                    shifted[i] = ext[j];
            end
        end
    end

    // word count saturates at all ones
    assign tally_inc = (&word_tally_reg) ? word_tally_reg : word_tally_reg + COUNT_WIDTH'(1);

    // ------------------------------------------------------------------
    // next state and result batch of the item at the input
    // ------------------------------------------------------------------
    always_comb
    begin
        window_next     = window_reg;
        fill_next       = fill_reg;
        word_open_next  = word_open_reg;
        word_tally_next = word_tally_reg;
        new_batch       = '0;
        new_batch.count = word_tally_reg;

        if (in_stream.is_end)
        begin
            // flush the window, close the word, report the count
            new_batch.bytes    = window_reg;
            new_batch.nbytes   = fill_reg;
            new_batch.has_end  = word_open_reg || (fill_reg != '0);
            new_batch.has_done = 1'b1;
            new_batch.count    = new_batch.has_end ? tally_inc : word_tally_reg;
            window_next        = '0;
            fill_next          = '0;
            word_open_next     = 1'b0;
            word_tally_next    = '0;
        end
        else if (full_match)
        begin
            new_batch.has_end = word_open_reg;
            window_next       = '0;
            fill_next         = '0;
            word_open_next    = 1'b0;
            word_tally_next   = word_open_reg ? tally_inc : word_tally_reg;
        end
        else
        begin
            new_batch.bytes  = ext;
            new_batch.nbytes = m_drop;
            window_next      = shifted;
            fill_next        = n_bytes - m_drop;
            word_open_next   = word_open_reg || (m_drop != '0);
        end
    end

    logic [CNT_W-1:0] new_total, cur_total;
    logic             new_has;

    assign new_total = CNT_W'(new_batch.nbytes) + CNT_W'(new_batch.has_end)
                     + CNT_W'(new_batch.has_done);
    assign new_has   = (new_total != '0);
    assign cur_total = CNT_W'(cur_reg.nbytes) + CNT_W'(cur_reg.has_end)
                     + CNT_W'(cur_reg.has_done);

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    logic out_xfer, cur_last, cur_free, in_xfer;

    assign cur_last        = (idx_reg == cur_total - CNT_W'(1));
    assign out_xfer        = out_stream.valid && out_stream.ready;
    assign cur_free        = !cur_valid_reg || (out_xfer && cur_last);
    // input waits only when the holding slot is full and cannot move up
    assign in_stream.ready = !pend_valid_reg || cur_free;
    assign in_xfer         = in_stream.valid && in_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            fill_reg       <= '0;
            word_open_reg  <= 1'b0;
            word_tally_reg <= '0;
        end
        else if (in_xfer)
        begin
            window_reg     <= window_next;
            fill_reg       <= fill_next;
            word_open_reg  <= word_open_next;
            word_tally_reg <= word_tally_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (cur_free)
            begin
                idx_reg <= '0;
                if (pend_valid_reg)
                begin
                    cur_valid_reg  <= 1'b1;
                    pend_valid_reg <= in_xfer && new_has;
                end
                else
                begin
                    cur_valid_reg <= in_xfer && new_has;
                end
            end
            else
            begin
                if (out_xfer)
                    idx_reg <= idx_reg + CNT_W'(1);
                if (in_xfer && new_has)
                    pend_valid_reg <= 1'b1;
            end
        end
    end

    // batch payload carries no reset
    always_ff @(posedge clk)
    begin
        if (cur_free)
        begin
            if (pend_valid_reg)
            begin
                cur_reg <= pend_reg;
                if (in_xfer)
                    pend_reg <= new_batch;
            end
            else if (in_xfer)
            begin
                cur_reg <= new_batch;
            end
        end
        else if (in_xfer)
        begin
            pend_reg <= new_batch;
        end
    end

    // ------------------------------------------------------------------
    // result selection
    // ------------------------------------------------------------------
    logic [dss_pkg::WORDS_W+COUNT_WIDTH-1:0] words_wide;

    assign words_wide = {{dss_pkg::WORDS_W{1'b0}}, cur_reg.count};

    assign out_stream.valid       = cur_valid_reg;
    assign out_stream.last_of_run = cur_last;

    always_comb
    begin
        out_stream.word_byte   = '0;
        out_stream.words_found = '0;
        if (idx_reg < CNT_W'(cur_reg.nbytes))
        begin
            out_stream.item_kind = dss_pkg::KIND_DATA;
            out_stream.word_byte = cur_reg.bytes[idx_reg[IDX_W-1:0]];
        end
        else if ((idx_reg == CNT_W'(cur_reg.nbytes)) && cur_reg.has_end)
        begin
            out_stream.item_kind = dss_pkg::KIND_END;
        end
        else
        begin
            out_stream.item_kind   = dss_pkg::KIND_DONE;
            out_stream.words_found = words_wide[dss_pkg::WORDS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_pend_behind_cur, pend_valid_reg, cur_valid_reg, "hold slot set while idle")
    `ASSERT_ALWAYS(a_fill_bound, fill_reg < NB_W'(MAX_DELIM), "window fill reached its depth")
    `ASSERT_NEXT(a_end_flush, in_xfer && in_stream.is_end, fill_reg == '0, "window kept at end")
    `ASSERT_NEXT(a_end_close, in_xfer && in_stream.is_end, !word_open_reg, "word open after end")

endmodule

>>> test/testbench.sv
// self-checking testbench of the delimiter string splitter: directed table, random phases
module testbench;

    // ------------------------------------------------------------------
    // constants of the run
    // ------------------------------------------------------------------

    localparam int MAX_DELIM     = 8;
    localparam int COUNT_WIDTH   = 16;
    localparam int WORD_MAX      = (1 << COUNT_WIDTH) - 1;
    localparam int MAX_GAP       = 17;      // longest idle stretch drawn per transfer
    localparam int HOLD_CYCLES   = 80;      // long sink stall that backs up the input
    localparam int SETTLE_CYCLES = 6;       // block latency plus margin once results are in
    localparam int STALL_LIMIT   = 2000;    // cycles with no transfer before giving up
    localparam int PHASE_ITEMS   = 17;      // least number of random items per delimiter setting
    localparam int REPORT_LIMIT  = 10;
    localparam int DIR_ROWS      = 28;
    localparam int PHASE_LEN [6] = '{3, 8, 15, 0, 1, 2};

    localparam logic [7:0] STAR = 8'h2A;    // default delimiter byte

    // one result transfer as the block should produce it
    typedef struct packed {
        dss_pkg::kind_t kind;
        logic [7:0]     data;
        logic [15:0]    words;
        logic           last;
    } split_result_t;

    // one row of stimulus: an input transfer or a delimiter change, optionally with the
    // number of results and the final result typed in by hand
    typedef struct packed {
        logic           is_cfg;
        logic           is_end;
        logic [7:0]     data;
        logic           typed;
        logic [3:0]     n_res;
        dss_pkg::kind_t last_kind;
        logic [7:0]     last_data;
        logic [15:0]    last_words;
        logic [3:0]     cfg_len;
        logic [63:0]    cfg_bytes;
    } feed_t;

    // ------------------------------------------------------------------
    // clock, buses and the block
    // ------------------------------------------------------------------

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [dss_pkg::APB_AW-1:0] paddr;
    logic [dss_pkg::APB_DW-1:0] pwdata;
    logic [dss_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    dss_in_if  in_bus ();
    dss_out_if out_bus ();

    delimiter_string_splitter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_stream  (in_bus),
        .out_stream (out_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shared state of the stimulus, the sink and the scoreboard
    // ------------------------------------------------------------------

    split_result_t expected_q [$];  // results still owed by the block, oldest first
    feed_t         feed_q [$];      // rows driven on the input, popped as they transfer
    int            fail_count  = 0;
    int            idle_cycles = 0;
    bit            in_calm     = 1'b0;  // sender offers back to back
    bit            out_calm    = 1'b0;  // sink never stalls
    int            hold_len    = 0;     // one-off long sink stall, taken by the sink process
    logic [7:0]    alpha [0:2];         // small byte alphabet of the current random phase

    // ------------------------------------------------------------------
    // splitter model: own copy of the window, word state and delimiter registers
    // ------------------------------------------------------------------

    logic [7:0]    pend_buf [0:MAX_DELIM-1];    // bytes that may still start a delimiter
    int            pend_cnt = 0;
    bit            in_word  = 1'b0;             // a word has data but no end marker yet
    int unsigned   word_cnt = 0;
    logic [3:0]    cfg_len;
    logic [63:0]   cfg_delim;
    split_result_t step_out [$];                // results of the step being modeled

    // lengths above the window size act as the window size
    function automatic int active_len();
        return (cfg_len > MAX_DELIM) ? MAX_DELIM : int'(cfg_len);
    endfunction

    // pending bytes are a prefix of the delimiter, a full match included
    function automatic bit pend_is_prefix(input int len);
        int i;
        if (pend_cnt > len)
            return 1'b0;
        for (i = 0; i < pend_cnt; i++)
            if (pend_buf[i] !== cfg_delim[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void put_result(input dss_pkg::kind_t k, input logic [7:0] d,
                                       input logic [15:0] w);
        split_result_t r;
        r.kind  = k;
        r.data  = d;
        r.words = w;
        r.last  = 1'b0;
        step_out.push_back(r);
    endfunction

    // oldest pending byte can no longer start a delimiter: it becomes word data
    function automatic void shift_front();
        int i;
        put_result(dss_pkg::KIND_DATA, pend_buf[0], 16'd0);
        in_word = 1'b1;
        for (i = 0; i < MAX_DELIM - 1; i++)
            pend_buf[i] = pend_buf[i+1];
        pend_buf[MAX_DELIM-1] = 8'd0;
        pend_cnt--;
    endfunction

    function automatic void close_word();
        if (!in_word)
            return;
        put_result(dss_pkg::KIND_END, 8'd0, 16'd0);
        in_word = 1'b0;
        if (word_cnt < WORD_MAX)
            word_cnt++;
    endfunction

    function automatic void clear_window();
        int i;
        for (i = 0; i < MAX_DELIM; i++)
            pend_buf[i] = 8'd0;
        pend_cnt = 0;
    endfunction

    // work out the results of one accepted input transfer and queue them
    function automatic void split_step(input logic is_end, input logic [7:0] b);
        int len;
        int i;
        step_out.delete();
        len = active_len();
        if (is_end)
        begin
            // flush the window, close the open word, report and start a fresh string
            while (pend_cnt > 0)
                shift_front();
            close_word();
            put_result(dss_pkg::KIND_DONE, 8'd0, 16'(word_cnt));
            clear_window();
            in_word  = 1'b0;
            word_cnt = 0;
        end
        else
        begin
            if (pend_cnt >= MAX_DELIM)
                shift_front();
            pend_buf[pend_cnt] = b;
            pend_cnt++;
            if (len > 0 && pend_cnt == len && pend_is_prefix(len))
            begin
                // whole delimiter: drop it and end the word, empty words vanish here
                clear_window();
                close_word();
            end
            else
            begin
                while (pend_cnt > 0 && (len == 0 || pend_cnt >= len || !pend_is_prefix(len)))
                    shift_front();
            end
        end
        if (step_out.size() > 0)
            step_out[step_out.size()-1].last = 1'b1;
        for (i = 0; i < step_out.size(); i++)
            expected_q.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // scoreboard and watchdog
    // ------------------------------------------------------------------

    function automatic void note_fail(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch %0d: %s", fail_count, msg);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        split_result_t want;
        feed_t         row;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            // results are checked before this edge's input is modeled: an input never
            // yields a result in the cycle it transfers
            if (out_bus.valid && out_bus.ready)
            begin
                moved = 1'b1;
                if (expected_q.size() == 0)
                    note_fail($sformatf("unexpected result kind %0d byte %h words %0d last %0b",
                                        out_bus.item_kind, out_bus.word_byte,
                                        out_bus.words_found, out_bus.last_of_run));
                else
                begin
                    want = expected_q.pop_front();
                    if (want.kind !== out_bus.item_kind || want.data !== out_bus.word_byte ||
                        want.words !== out_bus.words_found || want.last !== out_bus.last_of_run)
                        note_fail($sformatf({"expected kind %0d byte %h words %0d last %0b, ",
                                             "got kind %0d byte %h words %0d last %0b"},
                                            want.kind, want.data, want.words, want.last,
                                            out_bus.item_kind, out_bus.word_byte,
                                            out_bus.words_found, out_bus.last_of_run));
                end
            end
            if (in_bus.valid && in_bus.ready)
            begin
                moved = 1'b1;
                row = feed_q.pop_front();
                split_step(in_bus.is_end, in_bus.data_byte);
                // hand-typed rows also pin down the model itself
                if (row.typed && (step_out.size() != row.n_res ||
                    (row.n_res != 0 &&
                     (step_out[step_out.size()-1].kind  != row.last_kind ||
                      step_out[step_out.size()-1].data  != row.last_data ||
                      step_out[step_out.size()-1].words != row.last_words))))
                    note_fail($sformatf("table row byte %h end %0b: %0d modeled, %0d typed",
                                        row.data, row.is_end, step_out.size(), row.n_res));
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL delimiter_string_splitter");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // result sink: random stalls per transfer, one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : result_sink
        int gap;
        int k;
        out_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                k        = hold_len;
                hold_len = 0;
                out_bus.ready <= 1'b0;
                while (k > 0)
                begin
                    @(posedge clk);
                    k--;
                end
            end
            gap = out_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // ready stays high until a result transfers, so gap 0 keeps it up
            out_bus.ready <= 1'b1;
            do @(posedge clk); while (!out_bus.valid);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic feed_t plain(input logic e, input logic [7:0] d);
        feed_t r;
        r        = '0;
        r.is_end = e;
        r.data   = d;
        return r;
    endfunction

    function automatic feed_t typed(input logic e, input logic [7:0] d, input int n,
                                    input dss_pkg::kind_t k, input logic [7:0] ld,
                                    input logic [15:0] lw);
        feed_t r;
        r            = plain(e, d);
        r.typed      = 1'b1;
        r.n_res      = 4'(n);
        r.last_kind  = k;
        r.last_data  = ld;
        r.last_words = lw;
        return r;
    endfunction

    function automatic feed_t reconf(input logic [3:0] len, input logic [63:0] bytes);
        feed_t r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.cfg_len   = len;
        r.cfg_bytes = bytes;
        return r;
    endfunction

    // offer one input transfer after a random gap and wait until it is taken
    task automatic send_row(input feed_t r);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed_q.push_back(r);
        in_bus.valid     <= 1'b1;
        in_bus.is_end    <= r.is_end;
        in_bus.data_byte <= r.data;
        do @(posedge clk); while (!in_bus.ready);
    endtask

    // stop offering and wait until the block owes nothing, then let it settle
    task automatic drain_results();
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write length then bytes back to back; psel stays up between the two writes
    task automatic set_delimiter(input logic [3:0] len, input logic [63:0] bytes);
        dss_pkg::reg_idx_t idx;
        logic [63:0]       val;
        int                k;
        for (k = 0; k < 2; k++)
        begin
            idx = (k == 0) ? dss_pkg::REG_DELIM_LEN : dss_pkg::REG_DELIM_BYTES;
            val = (k == 0) ? 64'(len) : bytes;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 3'b000};
            pwdata  <= val;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            // register takes the value at this edge
            if (idx == dss_pkg::REG_DELIM_LEN)
                cfg_len = val[dss_pkg::LEN_W-1:0];
            else
                cfg_delim = val;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random text over the phase alphabet: mostly words and whole delimiters, some broken
    // delimiters, string ends and bytes from the full range
    task automatic random_text(input int budget);
        int         sent;
        int         act;
        int         n;
        int         k;
        int         len;
        logic [7:0] b;
        sent = 0;
        while (sent < budget)
        begin
            act = $urandom_range(0, 99);
            len = active_len();
            if (act < 50)
            begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                begin
                    b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : alpha[$urandom_range(0, 2)];
                    send_row(plain(1'b0, b));
                end
                sent += n;
            end
            else if (act < 75)
            begin
                for (k = 0; k < len; k++)
                    send_row(plain(1'b0, cfg_delim[8*k +: 8]));
                sent += len;
            end
            else if (act < 85)
            begin
                if (len > 1)
                begin
                    n = $urandom_range(1, len - 1);
                    for (k = 0; k < n; k++)
                        send_row(plain(1'b0, cfg_delim[8*k +: 8]));
                    send_row(plain(1'b0, 8'($urandom_range(0, 255))));
                    sent += n + 1;
                end
            end
            else if (act < 95)
            begin
                send_row(plain(1'b1, 8'($urandom_range(0, 255))));
                sent++;
            end
            else
            begin
                send_row(plain(1'b0, 8'($urandom_range(0, 255))));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    feed_t dir_rows [DIR_ROWS];

    initial
    begin : stimulus
        int          ph;
        int          k;
        logic [63:0] delim;

        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_bus.valid     <= 1'b0;
        in_bus.is_end    <= 1'b0;
        in_bus.data_byte <= 8'd0;
        cfg_len   = dss_pkg::DELIM_LEN_RESET;
        cfg_delim = dss_pkg::DELIM_BYTES_RESET;
        clear_window();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, starting from the reset delimiter: a single star
        dir_rows = '{
            // empty string reports zero words
            typed(1'b1, 8'hA5, 1, dss_pkg::KIND_DONE, 8'h00, 16'd0),
            typed(1'b0, 8'h61, 1, dss_pkg::KIND_DATA, 8'h61, 16'd0),
            typed(1'b0, STAR,  1, dss_pkg::KIND_END,  8'h00, 16'd0),
            // delimiter right after a delimiter: empty word, nothing comes out
            typed(1'b0, STAR,  0, dss_pkg::KIND_DATA, 8'h00, 16'd0),
            // zero and all-ones bytes are plain word data
            typed(1'b0, 8'h00, 1, dss_pkg::KIND_DATA, 8'h00, 16'd0),
            typed(1'b0, 8'hFF, 1, dss_pkg::KIND_DATA, 8'hFF, 16'd0),
            typed(1'b1, 8'h00, 2, dss_pkg::KIND_DONE, 8'h00, 16'd2),
            // splitting disabled: the star is ordinary data, one word in the string
            reconf(4'd0, 64'(STAR)),
            typed(1'b0, STAR,  1, dss_pkg::KIND_DATA, STAR,  16'd0),
            typed(1'b1, 8'hFF, 2, dss_pkg::KIND_DONE, 8'h00, 16'd1),
            // length beyond the window acts as eight, delimiter mixes zero and all-ones
            reconf(4'd15, 64'h00FF_00FF_00FF_00FF),
            plain(1'b0, 8'hFF), plain(1'b0, 8'h00), plain(1'b0, 8'hFF), plain(1'b0, 8'h00),
            plain(1'b0, 8'hFF), plain(1'b0, 8'h00), plain(1'b0, 8'hFF),
            // full match at string start closes nothing
            typed(1'b0, 8'h00, 0, dss_pkg::KIND_DATA, 8'h00, 16'd0),
            plain(1'b0, 8'h11), plain(1'b0, 8'hFF), plain(1'b0, 8'h00),
            // end flushes two pending bytes, closes the word and reports it
            typed(1'b1, 8'h00, 4, dss_pkg::KIND_DONE, 8'h00, 16'd1),
            // widest delimiter of all-ones bytes; string left open with bytes pending
            reconf(4'd8, 64'hFFFF_FFFF_FFFF_FFFF),
            plain(1'b0, 8'hFF), plain(1'b0, 8'hFE), plain(1'b0, 8'hFF), plain(1'b0, 8'hFF)
        };

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_cfg)
            begin
                drain_results();
                set_delimiter(dir_rows[r].cfg_len, dir_rows[r].cfg_bytes);
            end
            else
                send_row(dir_rows[r]);
        end

        // random phases; the first delimiter change lands mid string with bytes pending
        for (ph = 0; ph < 6; ph++)
        begin
            for (k = 0; k < 3; k++)
                alpha[k] = 8'($urandom_range(0, 255));
            delim = {$urandom, $urandom};
            for (k = 0; k < PHASE_LEN[ph] && k < MAX_DELIM; k++)
                delim[8*k +: 8] = alpha[$urandom_range(0, 2)];
            drain_results();
            set_delimiter(4'(PHASE_LEN[ph]), delim);
            // phase 1: sink holds off while the sender streams, so the block backs up
            // phase 4: a stretch with no idling on either side
            in_calm  = (ph == 1 || ph == 4);
            out_calm = (ph == 4);
            if (ph == 1)
                hold_len = HOLD_CYCLES;
            random_text(PHASE_ITEMS);
        end

        drain_results();
        if (fail_count == 0 && expected_q.size() == 0)
            $display("PASS delimiter_string_splitter");
        else
            $display("FAIL delimiter_string_splitter");
        $finish;
    end

endmodule
